// ===== rtl/lkfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkfc_pkg
// Shared types, constants and helpers for the keystream cipher block.
// ----------------------------------------------------------------------------
`default_nettype none

package lkfc_pkg;

  // keystream generator constants
  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic [31:0] SEED_RESET = 32'd123456789;
  localparam int unsigned KS_SHIFT   = 24;

  // header bytes
  localparam logic [7:0] MAGIC_0     = 8'h47;
  localparam logic [7:0] MAGIC_1     = 8'h52;
  localparam logic [7:0] MAGIC_2     = 8'h45;
  localparam logic [7:0] MAGIC_3     = 8'h4E;
  localparam logic [7:0] HDR_VERSION = 8'h01;

  // most results one item can cause
  localparam int unsigned MAX_RES = 6;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

  // configuration register indexes
  localparam int unsigned          CFG_IDX_W          = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SEED       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCRYPT_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE   = 2'd2;

  // frame phase codes
  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_VERSION = 2'd1;
  localparam logic [1:0] MODE_BODY    = 2'd2;
  localparam logic [1:0] MODE_RAW     = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } lkfc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
    logic       hdr_found;
    logic       status;
  } lkfc_out_t;

  typedef struct packed {
    logic [31:0] key_seed;
    logic        encrypt_enable;
    logic        decrypt_mode;
  } lkfc_cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]                count;
    lkfc_out_t [MAX_RES-1:0]         ent;
  } lkfc_batch_t;

  // build one result
  function automatic lkfc_out_t mk_res(input logic [7:0] b, input logic has,
                                       input logic lst, input logic enc,
                                       input logic st);
    lkfc_out_t r;
    r.out_byte  = b;
    r.has_byte  = has;
    r.out_last  = lst;
    r.hdr_found = enc;
    r.status    = st;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lkfc_frame_core.sv =====
// ----------------------------------------------------------------------------
// lkfc_frame_core
// Frame state, keystream step and header handling; builds the result batch
// for the item held in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkfc_frame_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lkfc_pkg::lkfc_cfg_t cfg_i,
  input  wire lkfc_pkg::lkfc_in_t  item_i,
  input  wire logic                take_i,
  output lkfc_pkg::lkfc_batch_t    batch_o
);
  import lkfc_pkg::*;

  logic [31:0] ks_q, ks_d;
  logic [2:0]  pos_q, pos_d;
  logic [23:0] hold_q, hold_d;
  logic [1:0]  mode_q, mode_d;

  logic [31:0] ks_base, ks_mul, ks_new;
  logic [7:0]  ks_byte, d;
  logic        lst, seed_load, is_magic;
  logic [1:0]  p;

  // keystream step: one constant multiply and add
  assign seed_load = (mode_q == MODE_HEADER) && (pos_q == 3'd0);
  assign ks_base   = seed_load ? cfg_i.key_seed : ks_q;
  assign ks_mul    = ks_base * LCG_MUL;
  assign ks_new    = ks_mul + LCG_ADD;
  assign ks_byte   = ks_new[KS_SHIFT +: 8];

  assign d   = item_i.data_byte;
  assign lst = item_i.last_byte;
  assign p   = (pos_q > 3'd3) ? 2'd3 : pos_q[1:0];

  assign is_magic = (hold_q[7:0] == MAGIC_0) && (hold_q[15:8] == MAGIC_1) &&
                    (hold_q[23:16] == MAGIC_2) && (d == MAGIC_3);

  // next state and results of this item
  always_comb begin
    batch_o = '0;
    ks_d    = ks_base;
    mode_d  = mode_q;
    pos_d   = pos_q;
    hold_d  = hold_q;

    if (!cfg_i.decrypt_mode) begin
      // write direction
      if (cfg_i.encrypt_enable) begin
        ks_d = ks_new;
      end
      if ((mode_q == MODE_HEADER) && cfg_i.encrypt_enable) begin
        batch_o.ent[0] = mk_res(MAGIC_0, 1'b1, 1'b0, 1'b0, 1'b0);
        batch_o.ent[1] = mk_res(MAGIC_1, 1'b1, 1'b0, 1'b0, 1'b0);
        batch_o.ent[2] = mk_res(MAGIC_2, 1'b1, 1'b0, 1'b0, 1'b0);
        batch_o.ent[3] = mk_res(MAGIC_3, 1'b1, 1'b0, 1'b0, 1'b0);
        batch_o.ent[4] = mk_res(HDR_VERSION, 1'b1, 1'b0, 1'b0, 1'b0);
        batch_o.ent[5] = mk_res(d ^ ks_byte, 1'b1, lst, 1'b0, 1'b0);
        batch_o.count  = CNT_W'(MAX_RES);
      end else begin
        batch_o.ent[0] = mk_res(cfg_i.encrypt_enable ? (d ^ ks_byte) : d,
                                1'b1, lst, 1'b0, 1'b0);
        batch_o.count  = CNT_W'(1);
      end
      mode_d = lst ? MODE_HEADER : MODE_BODY;
      pos_d  = 3'd0;
      hold_d = '0;
    end else begin
      // read direction
      case (mode_q)
        MODE_HEADER: begin
          if (p != 2'd3) begin
            if (lst) begin
              // short frame: replay buffered bytes raw
              for (int i = 0; i < 3; i++) begin
                if (i < int'(p)) begin
                  batch_o.ent[i] = mk_res(hold_q[8*i +: 8], 1'b1, 1'b0, 1'b0, 1'b0);
                end
              end
              batch_o.ent[{1'b0, p}] = mk_res(d, 1'b1, 1'b1, 1'b0, 1'b0);
              batch_o.count = CNT_W'(p) + CNT_W'(1);
              mode_d = MODE_HEADER;
              pos_d  = 3'd0;
              hold_d = '0;
            end else begin
              hold_d = hold_q | ({16'h0000, d} << {p, 3'b000});
              pos_d  = {1'b0, p} + 3'd1;
            end
          end else if (!is_magic) begin
            // no magic: flush the buffer and go raw
            batch_o.ent[0] = mk_res(hold_q[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
            batch_o.ent[1] = mk_res(hold_q[15:8], 1'b1, 1'b0, 1'b0, 1'b0);
            batch_o.ent[2] = mk_res(hold_q[23:16], 1'b1, 1'b0, 1'b0, 1'b0);
            batch_o.ent[3] = mk_res(d, 1'b1, lst, 1'b0, 1'b0);
            batch_o.count  = CNT_W'(4);
            mode_d = lst ? MODE_HEADER : MODE_RAW;
            pos_d  = 3'd0;
            hold_d = '0;
          end else if (lst) begin
            // magic but the frame ends before the version
            batch_o.ent[0] = mk_res(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
            batch_o.count  = CNT_W'(1);
            mode_d = MODE_HEADER;
            pos_d  = 3'd0;
            hold_d = '0;
          end else begin
            mode_d = MODE_VERSION;
            pos_d  = 3'd0;
            hold_d = '0;
          end
        end
        MODE_VERSION: begin
          if (d != HDR_VERSION) begin
            // wrong version: one error result, drop the rest
            batch_o.ent[0] = mk_res(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
            batch_o.count  = CNT_W'(1);
            if (lst) begin
              mode_d = MODE_HEADER;
              pos_d  = 3'd0;
              hold_d = '0;
            end else begin
              mode_d = MODE_RAW;
              pos_d  = 3'd1;
            end
          end else if (lst) begin
            // header only
            batch_o.ent[0] = mk_res(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
            batch_o.count  = CNT_W'(1);
            mode_d = MODE_HEADER;
            pos_d  = 3'd0;
            hold_d = '0;
          end else begin
            mode_d = MODE_BODY;
            pos_d  = 3'd0;
          end
        end
        MODE_BODY: begin
          ks_d = ks_new;
          batch_o.ent[0] = mk_res(d ^ ks_byte, 1'b1, lst, 1'b1, 1'b0);
          batch_o.count  = CNT_W'(1);
          if (lst) begin
            mode_d = MODE_HEADER;
            pos_d  = 3'd0;
            hold_d = '0;
          end
        end
        default: begin
          // raw pass (position zero) or drop (position one)
          if (pos_q == 3'd0) begin
            batch_o.ent[0] = mk_res(d, 1'b1, lst, 1'b0, 1'b0);
            batch_o.count  = CNT_W'(1);
          end
          if (lst) begin
            mode_d = MODE_HEADER;
            pos_d  = 3'd0;
            hold_d = '0;
          end
        end
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q   <= SEED_RESET;
      pos_q  <= 3'd0;
      hold_q <= '0;
      mode_q <= MODE_HEADER;
    end else if (take_i) begin
      ks_q   <= ks_d;
      pos_q  <= pos_d;
      hold_q <= hold_d;
      mode_q <= mode_d;
    end
  end

  // a last byte always closes the frame
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && item_i.last_byte |=> (mode_q == MODE_HEADER) && (pos_q == 3'd0)
                                   && (hold_q == '0))
    else $error("frame state not cleared after last byte");

  // the header buffer only holds bytes in the header phase
  a_hold_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_HEADER) |-> (hold_q == '0))
    else $error("header buffer not empty outside header phase");

  // marker results stand alone and close the frame
  a_marker_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && (batch_o.count != '0) && !batch_o.ent[0].has_byte
      |-> (batch_o.count == CNT_W'(1)) && batch_o.ent[0].out_last)
    else $error("marker result not alone or not last");

endmodule

`default_nettype wire

// ===== rtl/lkfc_out_serial.sv =====
// ----------------------------------------------------------------------------
// lkfc_out_serial
// Result register: holds one batch and hands its results out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lkfc_out_serial (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire lkfc_pkg::lkfc_batch_t batch_i,
  output logic                       load_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output lkfc_pkg::lkfc_out_t        out_data_o
);
  import lkfc_pkg::*;

  lkfc_out_t [MAX_RES-1:0] ent_q;
  logic [CNT_W-1:0]        rem_q;
  logic                    pop;

  assign out_valid_o  = (rem_q != '0);
  assign out_data_o   = ent_q[0];
  assign pop          = out_valid_o && out_ready_i;
  // a new batch may enter as the last result of the old one leaves
  assign load_ready_o = (rem_q == '0) || ((rem_q == CNT_W'(1)) && out_ready_i);

  // remaining count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i) begin
      rem_q <= batch_i.count;
    end else if (pop) begin
      rem_q <= rem_q - CNT_W'(1);
    end
  end

  // result entries, shifted towards the head on each transfer
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= batch_i.ent;
    end else if (pop) begin
      ent_q <= {lkfc_out_t'('0), ent_q[MAX_RES-1:1]};
    end
  end

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= CNT_W'(MAX_RES))
    else $error("result count out of range");

  a_load_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (rem_q == '0) || ((rem_q == CNT_W'(1)) && pop))
    else $error("batch loaded over pending results");

  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !load_i && (rem_q > CNT_W'(1)) |=> out_data_o == $past(ent_q[1]))
    else $error("result order broken");

endmodule

`default_nettype wire

// ===== rtl/lcg_keystream_file_cipher.sv =====
// ----------------------------------------------------------------------------
// lcg_keystream_file_cipher
// Byte-frame cipher with a linear congruential keystream and frame header.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one frame byte per
//   transfer, last_byte marking the end of the frame. Output channel
//   (out_valid_o/out_ready_i/out_data_o) gives result items in order.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while
//   the block is idle; index 0 seed, 1 encrypt enable, 2 decrypt mode.
//   A byte waits in the input register, its results in the result register.
//   Throughput: one byte per cycle while the receiver is ready and each
//   byte gives at most one result; a byte that gives several results
//   (header burst, buffered header replay, up to six) occupies the result
//   register until each has left through the single output port.
//   The keystream step (one 32-bit constant multiply-add) sits between the
//   input register and the result register.
//   Reset clears the frame state, loads the seed reset value and empties
//   both registers. When the receiver stalls the result register holds, and
//   the input register takes one more byte before in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_keystream_file_cipher (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire lkfc_pkg::lkfc_in_t               in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output lkfc_pkg::lkfc_out_t                   out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lkfc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [31:0]                      cfg_wdata_i
);
  import lkfc_pkg::*;

  lkfc_cfg_t   cfg_q;
  lkfc_in_t    in_q;
  logic        in_vld_q;
  logic        load_ready, take;
  lkfc_batch_t batch;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_seed       <= SEED_RESET;
      cfg_q.encrypt_enable <= 1'b0;
      cfg_q.decrypt_mode   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_SEED:       cfg_q.key_seed       <= cfg_wdata_i;
        CFG_ENCRYPT_ENABLE: cfg_q.encrypt_enable <= cfg_wdata_i[0];
        CFG_DECRYPT_MODE:   cfg_q.decrypt_mode   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register
  assign take       = in_vld_q && load_ready;
  assign in_ready_o = !in_vld_q || load_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  lkfc_frame_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .item_i  (in_q),
    .take_i  (take),
    .batch_o (batch)
  );

  lkfc_out_serial u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (take),
    .batch_i      (batch),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_valid_o)
    else $error("input stalled without pending work");

  a_take_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !take |=> in_vld_q && $stable(in_q))
    else $error("held input byte lost");

  a_no_result_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("pending result dropped");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the keystream frame cipher.
// A short table of directed frames covers pass-through, the header burst,
// the decoder's header cases and register extremes. A long burst with the
// receiver held off follows, then random frames under random register settings.
// Results are checked against a behavioural model or a typed row's fixed result.
// ----------------------------------------------------------------------------

module tb;
  import lkfc_pkg::*;

  localparam int DIR_ROWS     = 26;
  localparam int RANDOM_ITEMS = 140;
  localparam int HOLD_CYCLES  = 120;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_LIMIT  = 5000;
  // about 230 bytes, up to six results each, plus receiver stalls, sender gaps
  // and register loads, all well inside the watchdog timeout
  localparam int TIMEOUT_NS   = 10_000_000;

  // result flag columns of the directed table: {has, last, header found, status}
  localparam logic [3:0] F_NONE      = 4'b0000;
  localparam logic [3:0] F_DATA      = 4'b1000;
  localparam logic [3:0] F_DATA_LAST = 4'b1100;
  localparam logic [3:0] F_HDR_ERR   = 4'b0111;
  localparam logic [3:0] F_HDR_ONLY  = 4'b0110;
  localparam lkfc_cfg_t  NO_CFG      = '0;

  typedef struct packed {
    logic      reconfig;
    lkfc_cfg_t cfg;
    lkfc_in_t  item;
    logic      typed;
    lkfc_out_t fixed;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  lkfc_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  lkfc_out_t   out_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  // model copy of the registers and the frame state
  logic [31:0] seed_reg;
  logic        enc_en_reg;
  logic        dec_mode_reg;
  logic [31:0] ks_state;
  logic [2:0]  hdr_pos;
  logic [23:0] hdr_hold;
  logic [1:0]  frame_phase;

  lkfc_out_t   pending_results [$];
  lkfc_out_t   step_results [$];
  logic [7:0]  frame_bytes [$];
  row_t        dir_tab [DIR_ROWS];

  bit          hold_req = 1'b0;
  int          fail_count = 0;
  int          items_sent = 0;
  int          frames_sent = 0;
  int          config_loads = 0;
  int          results_seen = 0;

  lcg_keystream_file_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  function automatic lkfc_out_t make_result(input logic [7:0] b, input logic has,
                                            input logic lst, input logic enc,
                                            input logic st);
    lkfc_out_t r;
    r.out_byte  = b;
    r.has_byte  = has;
    r.out_last  = lst;
    r.hdr_found = enc;
    r.status    = st;
    return r;
  endfunction

  // one keystream step, returns the top byte of the new state
  function automatic logic [7:0] ks_next();
    ks_state = ks_state * LCG_MUL + LCG_ADD;
    return ks_state[31:24];
  endfunction

  task automatic close_frame();
    frame_phase = MODE_HEADER;
    hdr_pos     = 3'd0;
    hdr_hold    = 24'd0;
  endtask

  // model of one accepted byte: fills step_results
  task automatic cipher_predict(input lkfc_in_t item);
    logic [7:0] d;
    logic [1:0] p;
    bit         magic;
    int         k;
    d = item.data_byte;
    step_results.delete();
    if (frame_phase == MODE_HEADER && hdr_pos == 3'd0) ks_state = seed_reg;
    if (!dec_mode_reg) begin
      // encrypt direction: header burst at frame start if enabled, then one byte
      if (frame_phase == MODE_HEADER && enc_en_reg) begin
        step_results.push_back(make_result(MAGIC_0, 1'b1, 1'b0, 1'b0, 1'b0));
        step_results.push_back(make_result(MAGIC_1, 1'b1, 1'b0, 1'b0, 1'b0));
        step_results.push_back(make_result(MAGIC_2, 1'b1, 1'b0, 1'b0, 1'b0));
        step_results.push_back(make_result(MAGIC_3, 1'b1, 1'b0, 1'b0, 1'b0));
        step_results.push_back(make_result(HDR_VERSION, 1'b1, 1'b0, 1'b0, 1'b0));
      end
      if (enc_en_reg) d = d ^ ks_next();
      step_results.push_back(make_result(d, 1'b1, item.last_byte, 1'b0, 1'b0));
      if (item.last_byte) begin
        close_frame();
      end else begin
        frame_phase = MODE_BODY;
        hdr_pos     = 3'd0;
        hdr_hold    = 24'd0;
      end
    end else begin
      case (frame_phase)
        MODE_HEADER: begin
          p = (hdr_pos > 3'd3) ? 2'd3 : hdr_pos[1:0];
          if (p < 2'd3) begin
            // still buffering the first three bytes
            if (item.last_byte) begin
              for (k = 0; k < p; k++)
                step_results.push_back(make_result(hdr_hold[8*k +: 8], 1'b1, 1'b0,
                                                   1'b0, 1'b0));
              step_results.push_back(make_result(d, 1'b1, 1'b1, 1'b0, 1'b0));
              close_frame();
            end else begin
              hdr_hold = hdr_hold | ({16'd0, d} << (8 * p));
              hdr_pos  = {1'b0, p} + 3'd1;
            end
          end else begin
            // fourth byte decides whether the magic is there
            magic = hdr_hold[7:0] == MAGIC_0 && hdr_hold[15:8] == MAGIC_1 &&
                    hdr_hold[23:16] == MAGIC_2 && d == MAGIC_3;
            if (!magic) begin
              for (k = 0; k < 3; k++)
                step_results.push_back(make_result(hdr_hold[8*k +: 8], 1'b1, 1'b0,
                                                   1'b0, 1'b0));
              step_results.push_back(make_result(d, 1'b1, item.last_byte, 1'b0, 1'b0));
              if (item.last_byte) begin
                close_frame();
              end else begin
                frame_phase = MODE_RAW;
                hdr_pos     = 3'd0;
                hdr_hold    = 24'd0;
              end
            end else if (item.last_byte) begin
              step_results.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
              close_frame();
            end else begin
              frame_phase = MODE_VERSION;
              hdr_pos     = 3'd0;
              hdr_hold    = 24'd0;
            end
          end
        end
        MODE_VERSION: begin
          if (d != HDR_VERSION) begin
            step_results.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
            if (item.last_byte) begin
              close_frame();
            end else begin
              frame_phase = MODE_RAW;
              hdr_pos     = 3'd1;
            end
          end else if (item.last_byte) begin
            step_results.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
            close_frame();
          end else begin
            frame_phase = MODE_BODY;
            hdr_pos     = 3'd0;
          end
        end
        MODE_BODY: begin
          d = d ^ ks_next();
          step_results.push_back(make_result(d, 1'b1, item.last_byte, 1'b1, 1'b0));
          if (item.last_byte) close_frame();
        end
        default: begin
          // raw replay passes, drop swallows
          if (hdr_pos == 3'd0)
            step_results.push_back(make_result(d, 1'b1, item.last_byte, 1'b0, 1'b0));
          if (item.last_byte) close_frame();
        end
      endcase
    end
  endtask

  // compare one received result with the oldest expectation
  task automatic check_result(input lkfc_out_t got);
    lkfc_out_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: unexpected result byte=%02h has=%b last=%b hdr=%b status=%b",
                 $realtime, got.out_byte, got.has_byte, got.out_last,
                 got.hdr_found, got.status);
    end else begin
      want = pending_results.pop_front();
      if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
          got.out_last !== want.out_last || got.hdr_found !== want.hdr_found ||
          got.status !== want.status) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: mismatch want %02h/%b/%b/%b/%b got %02h/%b/%b/%b/%b",
                   $realtime, want.out_byte, want.has_byte, want.out_last,
                   want.hdr_found, want.status, got.out_byte, got.has_byte,
                   got.out_last, got.hdr_found, got.status);
      end
    end
  endtask

  // sender gap: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // one input transfer, then expectations, then an optional gap
  task automatic send_byte(input lkfc_in_t item, input logic typed,
                           input lkfc_out_t fixed, input int gap);
    int k;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cipher_predict(item);
    if (typed) begin
      pending_results.push_back(fixed);
    end else begin
      for (k = 0; k < step_results.size(); k++)
        pending_results.push_back(step_results[k]);
    end
    items_sent++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and let every outstanding byte work through
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write all three registers on consecutive edges
  task automatic load_config(input logic [31:0] seed, input logic enc,
                             input logic dec);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_KEY_SEED;
    cfg_wdata_i <= seed;
    @(posedge clk_i);
    seed_reg     = seed;
    cfg_idx_i   <= CFG_ENCRYPT_ENABLE;
    cfg_wdata_i <= {31'd0, enc};
    @(posedge clk_i);
    enc_en_reg   = enc;
    cfg_idx_i   <= CFG_DECRYPT_MODE;
    cfg_wdata_i <= {31'd0, dec};
    @(posedge clk_i);
    dec_mode_reg = dec;
    cfg_we_i    <= 1'b0;
    config_loads++;
  endtask

  task automatic random_config();
    logic [31:0] seed;
    int          pick;
    pick = $urandom_range(0, 5);
    if (pick == 0)      seed = 32'h0000_0000;
    else if (pick == 1) seed = 32'hFFFF_FFFF;
    else                seed = $urandom;
    load_config(seed, $urandom_range(0, 3) != 0, $urandom_range(0, 1) == 1);
  endtask

  // random frame content, shaped after the current direction
  task automatic build_frame();
    int         kind;
    int         len;
    logic [7:0] v;
    frame_bytes.delete();
    if (!dec_mode_reg) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        frame_bytes.push_back(MAGIC_0);
        frame_bytes.push_back(MAGIC_1);
        frame_bytes.push_back(MAGIC_2);
        frame_bytes.push_back(MAGIC_3);
      end
      if (kind < 6) begin
        // well-formed: header and a cipher body, sometimes empty
        frame_bytes.push_back(HDR_VERSION);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 10);
        repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 6) begin
        // wrong version and a tail to drop
        v = 8'($urandom_range(0, 255));
        if (v == HDR_VERSION) v = v ^ 8'h80;
        frame_bytes.push_back(v);
        repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 8) begin
        // near miss on the magic (sometimes a full match), then raw bytes
        frame_bytes.push_back(($urandom_range(0, 3) != 0) ? MAGIC_0
                                                          : 8'($urandom_range(0, 255)));
        frame_bytes.push_back(($urandom_range(0, 3) != 0) ? MAGIC_1
                                                          : 8'($urandom_range(0, 255)));
        frame_bytes.push_back(($urandom_range(0, 3) != 0) ? MAGIC_2
                                                          : 8'($urandom_range(0, 255)));
        frame_bytes.push_back(($urandom_range(0, 3) != 0) ? MAGIC_3
                                                          : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 9) begin
        // short frame, often a magic prefix
        frame_bytes.push_back(($urandom_range(0, 1) == 1) ? MAGIC_0
                                                          : 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) != 0) frame_bytes.push_back(MAGIC_1);
        if ($urandom_range(0, 1) == 1) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      // magic only: the frame ends on the fourth byte
    end
  endtask

  // send frame_bytes, sometimes changing registers part way through
  task automatic send_frame(input logic steady);
    lkfc_in_t item;
    int       k;
    int       split_at;
    split_at = -1;
    if (!steady && frame_bytes.size() > 1 && $urandom_range(0, 7) == 0)
      split_at = $urandom_range(1, frame_bytes.size() - 1);
    for (k = 0; k < frame_bytes.size(); k++) begin
      if (k == split_at) begin
        wait_idle();
        random_config();
      end
      item.data_byte = frame_bytes[k];
      item.last_byte = (k == frame_bytes.size() - 1);
      send_byte(item, 1'b0, '0, steady ? 0 : pick_gap());
    end
    frames_sent++;
  endtask

  // result side: random ready pattern and one long hold-off on request
  initial begin : result_sink
    int hold_left;
    int run_left;
    int r;
    bit ready_lvl;
    hold_left = 0;
    run_left  = 0;
    ready_lvl = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_result(out_data_o);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            ready_lvl = 1'b1;
            run_left  = $urandom_range(1, 12);
          end else if (r < 65) begin
            ready_lvl = 1'b1;
            run_left  = $urandom_range(30, 80);
          end else if (r < 95) begin
            ready_lvl = 1'b0;
            run_left  = $urandom_range(1, 3);
          end else begin
            ready_lvl = 1'b0;
            run_left  = $urandom_range(8, 30);
          end
        end
        out_ready_i <= ready_lvl;
        run_left--;
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    row_t row;
    int   r;
    int   drain;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_KEY_SEED;
    cfg_wdata_i <= '0;
    seed_reg     = SEED_RESET;
    enc_en_reg   = 1'b0;
    dec_mode_reg = 1'b0;
    ks_state     = SEED_RESET;
    close_frame();

    // columns: reconfig, {seed, enable, decrypt}, byte, last, typed, result
    // reset settings pass bytes through
    dir_tab[0]  = {1'b0, NO_CFG, 8'h00, 1'b0, 1'b1, 8'h00, F_DATA};
    dir_tab[1]  = {1'b0, NO_CFG, 8'hFF, 1'b1, 1'b1, 8'hFF, F_DATA_LAST};
    // header burst and cipher, zero seed
    dir_tab[2]  = {1'b1, 32'h0000_0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[3]  = {1'b0, NO_CFG, 8'hFF, 1'b1, 1'b0, 8'h00, F_NONE};
    // all-ones seed, then enable dropped mid-frame
    dir_tab[4]  = {1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'hA5, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[5]  = {1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h3C, 1'b1, 1'b1, 8'h3C, F_DATA_LAST};
    // decrypt: one-byte frame replayed raw
    dir_tab[6]  = {1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, MAGIC_0, 1'b1, 1'b1, MAGIC_0,
                   F_DATA_LAST};
    // magic with no version byte
    dir_tab[7]  = {1'b0, NO_CFG, MAGIC_0, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[8]  = {1'b0, NO_CFG, MAGIC_1, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[9]  = {1'b0, NO_CFG, MAGIC_2, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[10] = {1'b0, NO_CFG, MAGIC_3, 1'b1, 1'b1, 8'h00, F_HDR_ERR};
    // wrong version, tail dropped
    dir_tab[11] = {1'b0, NO_CFG, MAGIC_0, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[12] = {1'b0, NO_CFG, MAGIC_1, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[13] = {1'b0, NO_CFG, MAGIC_2, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[14] = {1'b0, NO_CFG, MAGIC_3, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[15] = {1'b0, NO_CFG, 8'h00, 1'b0, 1'b1, 8'h00, F_HDR_ERR};
    dir_tab[16] = {1'b0, NO_CFG, 8'hFF, 1'b1, 1'b0, 8'h00, F_NONE};
    // header only
    dir_tab[17] = {1'b0, NO_CFG, MAGIC_0, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[18] = {1'b0, NO_CFG, MAGIC_1, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[19] = {1'b0, NO_CFG, MAGIC_2, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[20] = {1'b0, NO_CFG, MAGIC_3, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[21] = {1'b0, NO_CFG, HDR_VERSION, 1'b1, 1'b1, 8'h00, F_HDR_ONLY};
    // no magic: four bytes replayed at once
    dir_tab[22] = {1'b0, NO_CFG, MAGIC_0, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[23] = {1'b0, NO_CFG, MAGIC_1, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[24] = {1'b0, NO_CFG, MAGIC_2, 1'b0, 1'b0, 8'h00, F_NONE};
    dir_tab[25] = {1'b0, NO_CFG, 8'h00, 1'b1, 1'b0, 8'h00, F_NONE};

    // reset
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (r = 0; r < DIR_ROWS; r++) begin
      row = dir_tab[r];
      if (row.reconfig) begin
        wait_idle();
        load_config(row.cfg.key_seed, row.cfg.encrypt_enable, row.cfg.decrypt_mode);
      end
      send_byte(row.item, row.typed, row.fixed, pick_gap());
    end

    // back-pressure: long frame at full rate while the receiver holds off
    wait_idle();
    load_config($urandom, 1'b1, 1'b0);
    frame_bytes.delete();
    repeat (40) frame_bytes.push_back(8'($urandom_range(0, 255)));
    hold_req = 1'b1;
    send_frame(1'b1);

    // random phases
    while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
      wait_idle();
      random_config();
      repeat ($urandom_range(2, 6)) begin
        build_frame();
        send_frame($urandom_range(0, 3) == 0);
      end
    end

    // drain
    in_valid_i <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      fail_count += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("covered %0d bytes in %0d random frames plus the directed table, %0d register loads",
             items_sent, frames_sent, config_loads);
    $display("%0d results compared, %0d failures counted", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
